// File: rtl/core/crlb_pkg.sv
// ----------------------------------------------------------------------------
// crlb_pkg
// Shared codes, characters and types of the console receive line buffer.
// ----------------------------------------------------------------------------
package crlb_pkg;

    // request codes of the input channel
    localparam logic REQ_RX   = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // result kinds
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // characters
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;

    // number of echo results of an erase
    localparam int unsigned ERASE_STEPS = 3;
    localparam int unsigned STEP_W      = 2;

    // what the result sequencer has to emit for one item
    typedef enum logic [1:0] {
        OP_ECHO       = 2'd0,
        OP_READ       = 2'd1,
        OP_READ_EMPTY = 2'd2,
        OP_ERASE      = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

endpackage

// File: rtl/core/crlb_in_if.sv
// ----------------------------------------------------------------------------
// crlb_in_if
// Request channel: received bytes and read requests.
// ----------------------------------------------------------------------------
interface crlb_in_if;

    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);

endinterface

// File: rtl/core/crlb_out_if.sv
// ----------------------------------------------------------------------------
// crlb_out_if
// Result channel: echo bytes and read responses.
// ----------------------------------------------------------------------------
interface crlb_out_if;

    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_byte;
    logic       read_empty;
    logic       last;

    modport source (
        output valid, output out_kind, output out_byte, output read_empty,
        output last, input ready
    );
    modport sink (
        input valid, input out_kind, input out_byte, input read_empty,
        input last, output ready
    );

endinterface

// File: rtl/core/crlb_ram.sv
// ----------------------------------------------------------------------------
// crlb_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module crlb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, data holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/crlb_seq.sv
// ----------------------------------------------------------------------------
// crlb_seq
// Result sequencer: holds one item's command and emits its results through
// an output register.
// ----------------------------------------------------------------------------
module crlb_seq
    import crlb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_ready,
    input  logic [7:0] ram_rdata,
    crlb_out_if.source result
);

    logic              s1_valid_reg, s1_valid_next;
    cmd_t              s1_cmd_reg, s1_cmd_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_empty_reg, out_empty_next;
    logic              out_last_reg, out_last_next;

    logic              advance;
    logic              res_kind;
    logic [7:0]        res_byte;
    logic              res_empty;
    logic              res_last;

    // result for the current step of the held command
    always_comb
    begin
        res_kind  = KIND_ECHO;
        res_byte  = s1_cmd_reg.data;
        res_empty = 1'b0;
        res_last  = 1'b1;
        case (s1_cmd_reg.op)
            OP_ECHO:
            begin
                res_kind = KIND_ECHO;
            end
            OP_READ:
            begin
                res_kind = KIND_READ;
                res_byte = ram_rdata;
            end
            OP_READ_EMPTY:
            begin
                res_kind  = KIND_READ;
                res_byte  = 8'h00;
                res_empty = 1'b1;
            end
            OP_ERASE:
            begin
                res_byte = (step_reg == STEP_W'(1)) ? CH_SP : CH_BS;
                res_last = (step_reg == STEP_W'(ERASE_STEPS - 1));
            end
            default:
            begin
                res_kind = KIND_ECHO;
            end
        endcase
    end

    assign advance   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign cmd_ready = !s1_valid_reg || (advance && res_last);

    // command stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_cmd_next   = s1_cmd_reg;
        step_next     = step_reg;
        if (advance)
        begin
            step_next = step_reg + STEP_W'(1);
            if (res_last)
            begin
                s1_valid_next = 1'b0;
            end
        end
        if (cmd_valid && cmd_ready)
        begin
            s1_valid_next = 1'b1;
            s1_cmd_next   = cmd;
            step_next     = '0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = res_kind;
            out_byte_next  = res_byte;
            out_empty_next = res_empty;
            out_last_next  = res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg    <= s1_cmd_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.out_kind   = out_kind_reg;
    assign result.out_byte   = out_byte_reg;
    assign result.read_empty = out_empty_reg;
    assign result.last       = out_last_reg;

endmodule

// File: rtl/core/console_rx_line_buffer.sv
// ----------------------------------------------------------------------------
// console_rx_line_buffer
// Console receive ring buffer with backspace line editing and echo.
// ----------------------------------------------------------------------------
// Received bytes are stored in a ring of BUF_DEPTH slots (one slot always
// stays free, so it holds BUF_DEPTH - 1 bytes) and echoed; a carriage return
// is stored and echoed as a line feed, backspace or delete on a non-empty
// buffer drops the newest byte and echoes backspace, space, backspace. Bytes
// arriving while full, and erases on an empty buffer, are dropped with no
// result. A read request pops the oldest byte or reports empty. Pointers are
// updated at acceptance, so one item is taken per cycle for echoes and reads
// while the result side does not stall; an erase holds the request side until
// the last of its three echo results enters the single output register, which
// emits one result a cycle when not stalled. The buffer read port and command
// register load at the accepting edge, the output register when the command
// stage advances. The RAM is uninitialized; no clearing pass is needed.
module console_rx_line_buffer
    import crlb_pkg::*;
#(
    parameter int unsigned BUF_DEPTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    crlb_in_if.sink    rx_req,
    crlb_out_if.source result
);

    localparam int unsigned PTR_W = $clog2(BUF_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUF_DEPTH - 1);

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc, wr_ptr_dec, rd_ptr_inc;

    logic       accept;
    logic       buf_empty, buf_full;
    logic       is_erase;
    logic [7:0] store_byte;
    logic       do_store, do_read;
    logic       cmd_valid, cmd_ready;
    cmd_t       cmd;
    logic [7:0] ram_rdata;

    // pointer arithmetic with wrap at BUF_DEPTH
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_dec = (wr_ptr_reg == '0) ? PTR_LAST : wr_ptr_reg - PTR_W'(1);
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);

    assign buf_empty = (rd_ptr_reg == wr_ptr_reg);
    assign buf_full  = (wr_ptr_inc == rd_ptr_reg);

    assign rx_req.ready = cmd_ready;
    assign accept       = rx_req.valid && cmd_ready;

    // request decode
    assign is_erase   = (rx_req.rx_byte == CH_BS) || (rx_req.rx_byte == CH_DEL);
    assign store_byte = (rx_req.rx_byte == CH_CR) ? CH_LF : rx_req.rx_byte;

    always_comb
    begin
        do_store    = 1'b0;
        do_read     = 1'b0;
        cmd_valid   = 1'b0;
        cmd.op      = OP_ECHO;
        cmd.data    = store_byte;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (accept)
        begin
            if (rx_req.req_type == REQ_READ)
            begin
                cmd_valid = 1'b1;
                if (buf_empty)
                begin
                    cmd.op = OP_READ_EMPTY;
                end
                else
                begin
                    cmd.op      = OP_READ;
                    do_read     = 1'b1;
                    rd_ptr_next = rd_ptr_inc;
                end
            end
            else if (is_erase)
            begin
                if (!buf_empty)
                begin
                    cmd_valid   = 1'b1;
                    cmd.op      = OP_ERASE;
                    wr_ptr_next = wr_ptr_dec;
                end
            end
            else if (!buf_full)
            begin
                cmd_valid   = 1'b1;
                cmd.op      = OP_ECHO;
                do_store    = 1'b1;
                wr_ptr_next = wr_ptr_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // line storage
    crlb_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_store),
        .waddr (wr_ptr_reg),
        .wdata (store_byte),
        .re    (do_read),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // result sequencing
    crlb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .ram_rdata (ram_rdata),
        .result    (result)
    );

    // pointers stay inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg <= PTR_LAST) && (rd_ptr_reg <= PTR_LAST))
        else $error("buffer pointer out of range");

    // a stored byte leaves the buffer non-empty
    assert property (@(posedge clk) disable iff (!rst_n)
        do_store |=> (wr_ptr_reg != rd_ptr_reg))
        else $error("store left the buffer empty");

    // an empty read carries a zero byte and is a read response
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.read_empty) |->
            (result.out_byte == 8'h00) && (result.out_kind == KIND_READ) && result.last)
        else $error("malformed empty read response");

    // a taken non-final result is followed at once by the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && !result.last) |=> result.valid)
        else $error("gap inside an erase echo sequence");

endmodule
